>>> hw/rtl/hesd_pkg.sv
// hesd_pkg: shared types, character codes and the named reference table
// for the html entity stream decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hesd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } in_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NUM,
      ST_NAME,
      ST_FAIL,
      ST_REP,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      SRC_HEAD,
      SRC_AMP,
      SRC_REP
   } emit_src_type;

   typedef struct packed {
      logic         load;
      logic         start_decode;
      logic         step_digit;
      logic         load_named;
      logic         load_num;
      logic         emit;
      emit_src_type emit_src;
      logic         shift;
      logic         shift_entity;
      logic         flush;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic head_amp;
      logic semi_found;
      logic win_full;
      logic last;
      logic slot_free;
      logic body_hash;
      logic digit_bad;
      logic digits_done;
      logic cp_zero;
      logic name_found;
      logic rep_last;
      logic pend_v;
   } status_type;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LX   = 8'h78;
   localparam logic [7:0] CH_UX   = 8'h58;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LF   = 8'h66;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UF   = 8'h46;

   typedef struct packed {
      logic [2:0]  nlen;
      logic [47:0] name;
      logic [1:0]  rlen;
      logic [23:0] rep;
   } name_entry_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  rlen;
      logic [23:0] rep;
   } name_hit_type;

   localparam int NAME_COUNT = 24;

   localparam name_entry_type NAME_TAB [NAME_COUNT] = '{
      '{3'd3, {"amp", 24'h0},    2'd1, 24'h260000},
      '{3'd2, {"lt", 32'h0},     2'd1, 24'h3C0000},
      '{3'd2, {"gt", 32'h0},     2'd1, 24'h3E0000},
      '{3'd4, {"quot", 16'h0},   2'd1, 24'h220000},
      '{3'd4, {"apos", 16'h0},   2'd1, 24'h270000},
      '{3'd4, {"nbsp", 16'h0},   2'd2, 24'hC2A000},
      '{3'd4, {"ensp", 16'h0},   2'd3, 24'hE28082},
      '{3'd4, {"emsp", 16'h0},   2'd3, 24'hE28083},
      '{3'd6, {"middot"},        2'd2, 24'hC2B700},
      '{3'd6, {"hellip"},        2'd3, 24'hE280A6},
      '{3'd5, {"mdash", 8'h0},   2'd3, 24'hE28094},
      '{3'd5, {"ndash", 8'h0},   2'd3, 24'hE28093},
      '{3'd5, {"times", 8'h0},   2'd2, 24'hC39700},
      '{3'd4, {"copy", 16'h0},   2'd2, 24'hC2A900},
      '{3'd3, {"reg", 24'h0},    2'd2, 24'hC2AE00},
      '{3'd5, {"trade", 8'h0},   2'd3, 24'hE284A2},
      '{3'd5, {"laquo", 8'h0},   2'd2, 24'hC2AB00},
      '{3'd5, {"raquo", 8'h0},   2'd2, 24'hC2BB00},
      '{3'd5, {"lsquo", 8'h0},   2'd3, 24'hE28098},
      '{3'd5, {"rsquo", 8'h0},   2'd3, 24'hE28099},
      '{3'd5, {"ldquo", 8'h0},   2'd3, 24'hE2809C},
      '{3'd5, {"rdquo", 8'h0},   2'd3, 24'hE2809D},
      '{3'd4, {"bull", 16'h0},   2'd3, 24'hE280A2},
      '{3'd4, {"sect", 16'h0},   2'd2, 24'hC2A700}
   };

   // body is left aligned, bytes past len are zero
   function automatic name_hit_type name_lookup(input logic [47:0] body,
                                                input logic [3:0]  len);
      name_hit_type h;
      h = '0;
      for (int t = 0; t < NAME_COUNT; t++) begin
         if ({1'b0, NAME_TAB[t].nlen} == len && NAME_TAB[t].name == body) begin
            h.found = 1'b1;
            h.rlen  = NAME_TAB[t].rlen;
            h.rep   = NAME_TAB[t].rep;
         end
      end
      return h;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hesd_ctrl.sv
// hesd_ctrl: sequencing state machine of the entity decoder
// depends on hesd_pkg; drives commands to hesd_datapath
`timescale 1ns / 1ps
`default_nettype none
module hesd_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  hesd_pkg::status_type status,
   output hesd_pkg::cmd_type    cmd
);
   import hesd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit_src = SRC_HEAD;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.len_zero) begin
               state_in = ST_FLUSH;
            end else if (!status.head_amp) begin
               if (status.slot_free) begin
                  cmd.emit  = 1'b1;
                  cmd.shift = 1'b1;
               end
            end else if (status.semi_found) begin
               cmd.start_decode = 1'b1;
               state_in = status.body_hash ? ST_NUM : ST_NAME;
            end else if (status.win_full || status.last) begin
               if (status.slot_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_src = SRC_AMP;
                  cmd.shift    = 1'b1;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_NAME: begin
            if (status.name_found) begin
               cmd.load_named = 1'b1;
               state_in = ST_REP;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_NUM: begin
            if (status.digits_done) begin
               if (status.cp_zero) begin
                  state_in = ST_FAIL;
               end else begin
                  cmd.load_num = 1'b1;
                  state_in = ST_REP;
               end
            end else if (status.digit_bad) begin
               state_in = ST_FAIL;
            end else begin
               cmd.step_digit = 1'b1;
            end
         end
         ST_FAIL: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_AMP;
               cmd.shift    = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_REP: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_REP;
               if (status.rep_last) begin
                  cmd.shift        = 1'b1;
                  cmd.shift_entity = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_v) begin
               state_in = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/hesd_datapath.sv
// hesd_datapath: held byte window, code point accumulator, replacement
// bytes and output register; depends on hesd_pkg, driven by hesd_ctrl
`timescale 1ns / 1ps
`default_nettype none
module hesd_datapath #(
   parameter int DEPTH = 13
) (
   input  wire                  clock,
   input  wire                  reset,
   input  hesd_pkg::in_type     req_data,
   input  hesd_pkg::cmd_type    cmd,
   output hesd_pkg::status_type status,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output hesd_pkg::out_type    rsp_data
);
   import hesd_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [7:0]      win_ff [DEPTH];
   logic [LW-1:0]   len_ff;
   logic            last_ff;
   logic [IW-1:0]   q_ff;
   logic [IW-1:0]   idx_ff;
   logic            hex_ff;
   logic [25:0]     cp_ff;
   logic            big_ff;
   logic [3:0][7:0] rep_ff;
   logic [1:0]      rep_n_ff;
   logic [1:0]      rep_i_ff;
   logic [7:0]      pend_ff;
   logic            pend_v_ff;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;

   logic            semi_found;
   logic [IW-1:0]   q_comb;
   logic            hex_comb;
   logic [7:0]      dig_c;
   logic [3:0]      dig_val;
   logic            dig_bad;
   logic [29:0]     mul;
   logic [29:0]     wide;
   logic [3:0]      ent_len;
   logic [47:0]     body;
   name_hit_type    hit;
   logic [3:0][7:0] num_rep;
   logic [1:0]      num_n;
   logic [7:0]      emit_byte;
   logic [LW-1:0]   amt;
   logic            slot_free;

   always_comb begin
      semi_found = 1'b0;
      q_comb     = '0;
      for (int j = DEPTH - 1; j >= 1; j--) begin
         if (LW'(j) < len_ff && win_ff[j] == CH_SEMI) begin
            semi_found = 1'b1;
            q_comb     = IW'(j);
         end
      end
   end

   assign hex_comb = (q_comb > IW'(2)) && (win_ff[2] == CH_LX || win_ff[2] == CH_UX);

   assign dig_c = win_ff[idx_ff];
   always_comb begin
      dig_bad = 1'b0;
      dig_val = '0;
      if (dig_c inside {[CH_0:CH_9]}) begin
         dig_val = 4'(dig_c - CH_0);
      end else if (hex_ff && (dig_c inside {[CH_LA:CH_LF]})) begin
         dig_val = 4'(dig_c - CH_LA + 8'd10);
      end else if (hex_ff && (dig_c inside {[CH_UA:CH_UF]})) begin
         dig_val = 4'(dig_c - CH_UA + 8'd10);
      end else begin
         dig_bad = 1'b1;
      end
   end

   // low 26 bits wrap exactly, big flags anything above
   assign mul  = hex_ff ? {cp_ff, 4'b0} : (30'(cp_ff) * 30'd10);
   assign wide = mul + 30'(dig_val);

   assign ent_len = 4'(q_ff) - 4'd1;
   for (genvar i = 0; i < 6; i++) begin : g_body
      if (i + 1 < DEPTH) begin : g_in
         assign body[47-8*i -: 8] = (4'(i) < ent_len) ? win_ff[i+1] : 8'h00;
      end else begin : g_out
         assign body[47-8*i -: 8] = 8'h00;
      end
   end
   assign hit = name_lookup(body, ent_len);

   always_comb begin
      num_rep = '0;
      if (!big_ff && cp_ff < 26'h80) begin
         num_n      = 2'd0;
         num_rep[0] = cp_ff[7:0];
      end else if (!big_ff && cp_ff < 26'h800) begin
         num_n      = 2'd1;
         num_rep[0] = 8'hC0 | {3'b0, cp_ff[10:6]};
         num_rep[1] = 8'h80 | {2'b0, cp_ff[5:0]};
      end else if (!big_ff && cp_ff < 26'h10000) begin
         num_n      = 2'd2;
         num_rep[0] = 8'hE0 | {4'b0, cp_ff[15:12]};
         num_rep[1] = 8'h80 | {2'b0, cp_ff[11:6]};
         num_rep[2] = 8'h80 | {2'b0, cp_ff[5:0]};
      end else begin
         num_n      = 2'd3;
         num_rep[0] = 8'hF0 | cp_ff[25:18];
         num_rep[1] = 8'h80 | {2'b0, cp_ff[17:12]};
         num_rep[2] = 8'h80 | {2'b0, cp_ff[11:6]};
         num_rep[3] = 8'h80 | {2'b0, cp_ff[5:0]};
      end
   end

   always_comb begin
      case (cmd.emit_src)
         SRC_HEAD: emit_byte = win_ff[0];
         SRC_AMP:  emit_byte = CH_AMP;
         SRC_REP:  emit_byte = rep_ff[rep_i_ff];
         default:  emit_byte = win_ff[0];
      endcase
   end

   assign amt       = cmd.shift_entity ? (LW'(q_ff) + LW'(1)) : LW'(1);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         win_ff[len_ff[IW-1:0]] <= req_data.in_byte;
         last_ff <= req_data.in_last;
      end
      if (cmd.shift) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (i + int'(amt) < DEPTH) begin
               win_ff[i] <= win_ff[IW'(i + int'(amt))];
            end
         end
      end
      if (cmd.start_decode) begin
         q_ff   <= q_comb;
         hex_ff <= hex_comb;
         idx_ff <= hex_comb ? IW'(3) : IW'(2);
         cp_ff  <= '0;
         big_ff <= 1'b0;
      end
      if (cmd.step_digit) begin
         cp_ff  <= wide[25:0];
         big_ff <= big_ff | (|wide[29:26]);
         idx_ff <= idx_ff + IW'(1);
      end
      if (cmd.load_named) begin
         rep_ff[0] <= hit.rep[23:16];
         rep_ff[1] <= hit.rep[15:8];
         rep_ff[2] <= hit.rep[7:0];
         rep_ff[3] <= 8'h00;
         rep_n_ff  <= hit.rlen - 2'd1;
         rep_i_ff  <= 2'd0;
      end
      if (cmd.load_num) begin
         rep_ff   <= num_rep;
         rep_n_ff <= num_n;
         rep_i_ff <= 2'd0;
      end
      if (cmd.emit && cmd.emit_src == SRC_REP) begin
         rep_i_ff <= rep_i_ff + 2'd1;
      end
      if (cmd.emit) begin
         pend_ff <= emit_byte;
      end
      if ((cmd.emit && pend_v_ff) || cmd.flush) begin
         rsp_byte_ff <= pend_ff;
         rsp_last_ff <= cmd.flush & last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            len_ff <= len_ff + LW'(1);
         end else if (cmd.shift) begin
            len_ff <= len_ff - amt;
         end
         if (cmd.emit) begin
            pend_v_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_v_ff <= 1'b0;
         end
         if ((cmd.emit && pend_v_ff) || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.len_zero    = (len_ff == '0);
   assign status.head_amp    = (win_ff[0] == CH_AMP);
   assign status.semi_found  = semi_found;
   assign status.win_full    = (len_ff == LW'(DEPTH));
   assign status.last        = last_ff;
   assign status.slot_free   = slot_free;
   assign status.body_hash   = (win_ff[1] == CH_HASH);
   assign status.digit_bad   = dig_bad;
   assign status.digits_done = (idx_ff == q_ff);
   assign status.cp_zero     = (cp_ff == '0) && !big_ff;
   assign status.name_found  = hit.found;
   assign status.rep_last    = (rep_i_ff == rep_n_ff);
   assign status.pend_v      = pend_v_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.out_byte = rsp_byte_ff;
   assign rsp_data.out_last = rsp_last_ff;

endmodule
`default_nettype wire

>>> hw/rtl/html_entity_stream_decoder.sv
// html entity stream decoder: one input byte per transaction; held bytes
// are scanned or emitted in turn, digits and replacement bytes one by one;
// a byte is taken only when the previous one is done, its result valid with the next ready
// a failed reference emits its ampersand and rescans its held bytes through the window
// synchronous reset clears window length, pending flag and output valid, and sets the controller idle
`timescale 1ns / 1ps
`default_nettype none
module html_entity_stream_decoder #(
   parameter int WINDOW_BYTES = 12
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  hesd_pkg::in_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output hesd_pkg::out_type rsp_data
);
   import hesd_pkg::*;

   localparam int EFF   = (WINDOW_BYTES > 15) ? 15 :
                          ((WINDOW_BYTES < 1) ? 1 : WINDOW_BYTES);
   localparam int DEPTH = EFF + 1;

   cmd_type    cmd;
   status_type status;

   hesd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hesd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.pend_v)
      else $error("pending byte left when ready");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("ready right after a transaction");

   a_held_amp: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !status.len_zero |-> status.head_amp)
      else $error("held window does not start with ampersand");

endmodule
`default_nettype wire
